### rtl/bda_pkg.sv
// Shared types and constants for the button debouncer with auto-repeat.
// Used by the lane, merge, top level and checker; depends on nothing else.
package bda_pkg;

  localparam int NUM_BUTTONS_DEF = 10;
  localparam int RAW_W           = 10;
  localparam int MASK_W          = 10;
  localparam int TIME_W          = 32;
  localparam int CFG_W           = 16;
  localparam int IDX_W           = 4;
  // Full button index before truncation to the action_index field.
  localparam int WIDE_IDX_W      = 5;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [CFG_W-1:0] DELAY_RESET    = 16'd350;
  localparam logic [CFG_W-1:0] INTERVAL_RESET = 16'd120;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_DELAY    = 2'd1,
    REG_INTERVAL = 2'd2,
    REG_UNUSED   = 2'd3
  } cfg_reg_t;

  // What one lane reports for the frame under way.
  typedef struct packed {
    logic pressed;
    logic just;
    logic hit;
  } lane_flags_t;

  // One result request.
  typedef struct packed {
    logic [MASK_W-1:0] pressed_mask;
    logic [MASK_W-1:0] just_pressed_mask;
    logic              action_valid;
    logic [IDX_W-1:0]  action_index;
    logic              action_is_repeat;
  } result_t;

endpackage

### rtl/bda_lane.sv
// One button lane: raw level tracking, debounce timer and repeat due time.
// Depends on bda_pkg.
module bda_lane
  import bda_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              level,
  input  logic [TIME_W-1:0] now,
  input  logic [CFG_W-1:0]  debounce_ms,
  input  logic [CFG_W-1:0]  repeat_delay_ms,
  input  logic [CFG_W-1:0]  repeat_interval_ms,
  input  logic              rearm,
  output lane_flags_t       flags
);

  logic              last_raw_r, last_raw_nxt;
  logic              pressed_r, pressed_nxt;
  logic [TIME_W-1:0] change_time_r, change_time_nxt;
  logic [TIME_W-1:0] due_r, due_nxt;

  logic              changed, settled, flip, just;
  logic [TIME_W-1:0] elapsed, due_diff, due_mid;
  logic              old_due_hit, new_due_hit;

  always_comb begin
    changed  = (level != last_raw_r);
    elapsed  = now - change_time_r;
    settled  = !changed && (elapsed > {{(TIME_W-CFG_W){1'b0}}, debounce_ms});
    flip     = settled && (level != pressed_r);
    just     = flip && level;
    pressed_nxt = flip ? level : pressed_r;

    if (flip) begin
      due_mid = level ? (now + {{(TIME_W-CFG_W){1'b0}}, repeat_delay_ms}) : '0;
    end else begin
      due_mid = due_r;
    end

    // Due test runs in parallel with the debounce path: a fresh arming at
    // now + delay is due only when the delay is zero and the sum is nonzero.
    due_diff    = now - due_r;
    old_due_hit = (due_r != '0) && !due_diff[TIME_W-1];
    new_due_hit = (repeat_delay_ms == '0) && (now != '0);

    flags.pressed = pressed_nxt;
    flags.just    = just;
    flags.hit     = pressed_nxt && (just ? new_due_hit : old_due_hit);

    last_raw_nxt    = level;
    change_time_nxt = changed ? now : change_time_r;
  end

  // The re-arm request comes back from the merge stage, so it is kept out of
  // the block that produces the lane flags.
  assign due_nxt = rearm ? (now + {{(TIME_W-CFG_W){1'b0}}, repeat_interval_ms})
                         : due_mid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r    <= 1'b0;
      pressed_r     <= 1'b0;
      change_time_r <= '0;
      due_r         <= '0;
    end else if (en) begin
      last_raw_r    <= last_raw_nxt;
      pressed_r     <= pressed_nxt;
      change_time_r <= change_time_nxt;
      due_r         <= due_nxt;
    end
  end

endmodule

### rtl/bda_merge.sv
// Merging stage: picks the winning lane for an action and flags the
// lane to re-arm. Depends on bda_pkg.
module bda_merge
  import bda_pkg::*;
#(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  logic                   req_action,
  input  logic                   allow_repeat,
  input  logic [NUM_BUTTONS-1:0] just_vec,
  input  logic [NUM_BUTTONS-1:0] hit_vec,
  output logic [NUM_BUTTONS-1:0] rearm_vec,
  output logic                   action_valid,
  output logic [IDX_W-1:0]       action_index,
  output logic                   action_is_repeat
);

  logic                   any_just, use_repeat;
  logic [NUM_BUTTONS-1:0] cand, first;
  logic [WIDE_IDX_W-1:0]  idx;

  always_comb begin
    any_just   = |just_vec;
    use_repeat = req_action && !any_just && allow_repeat && (|hit_vec);
    cand       = any_just ? just_vec : hit_vec;
    first      = cand & (~cand + NUM_BUTTONS'(1));

    idx = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (first[i]) begin
        idx = WIDE_IDX_W'(i);
      end
    end

    action_valid     = req_action && (any_just || use_repeat);
    action_index     = action_valid ? idx[IDX_W-1:0] : '0;
    action_is_repeat = use_repeat;
    rearm_vec        = use_repeat ? first : '0;
  end

endmodule

### rtl/button_debounce_autorepeat_top.sv
// Top level of the button debouncer with auto-repeat: config registers,
// button lanes, merge stage and a two-entry output buffer. Depends on bda_pkg.
//
//   channel  | direction | handshake           | payload
//   in_      | request   | in_valid / in_stall | req_type, raw_levels, now_ms,
//            |           |                     | allow_repeat
//   out_     | result    | out_valid/out_stall | pressed_mask, just_pressed_mask,
//            |           |                     | action_valid, action_index,
//            |           |                     | action_is_repeat
//   cfg_     | write     | cfg_we              | cfg_index, cfg_data
//
// All lanes update their state at the accepting edge and the result is
// registered in the output register, or in the skid entry while a result
// is stalled; one request per cycle is sustained while in_stall is low.
// Reset is synchronous and active low; it clears all lane state, restores
// the register defaults and empties the output buffer.
// A skid entry behind the output register lets the block take one more
// request while a result is stalled; in_stall rises only when both are full.
module button_debounce_autorepeat_top
  import bda_pkg::*;
#(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [RAW_W-1:0]   in_raw_levels,
  input  logic [TIME_W-1:0]  in_now_ms,
  input  logic               in_allow_repeat,

  output logic               out_valid,
  input  logic               out_stall,
  output logic [MASK_W-1:0]  out_pressed_mask,
  output logic [MASK_W-1:0]  out_just_pressed_mask,
  output logic               out_action_valid,
  output logic [IDX_W-1:0]   out_action_index,
  output logic               out_action_is_repeat,

  input  logic               cfg_we,
  input  cfg_reg_t           cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  // Configuration registers. Writes to the unused index are dropped.
  logic [CFG_W-1:0] debounce_r, delay_r, interval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
      delay_r    <= DELAY_RESET;
      interval_r <= INTERVAL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE: debounce_r <= cfg_data;
        REG_DELAY:    delay_r    <= cfg_data;
        REG_INTERVAL: interval_r <= cfg_data;
        default:      ;
      endcase
    end
  end

  logic in_accept;
  assign in_accept = in_valid && !in_stall;

  // Active-high level per button. Buttons past the raw input width read
  // as pressed, matching a level of zero on a missing pin.
  logic [NUM_BUTTONS-1:0] level_vec, just_vec, hit_vec, pressed_vec, rearm_vec;
  lane_flags_t            flags [NUM_BUTTONS];

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    if (i < RAW_W) begin : g_pin
      assign level_vec[i] = ~in_raw_levels[i];
    end else begin : g_nopin
      assign level_vec[i] = 1'b1;
    end

    bda_lane u_lane (
      .clk                (clk),
      .rst_n              (rst_n),
      .en                 (in_accept),
      .level              (level_vec[i]),
      .now                (in_now_ms),
      .debounce_ms        (debounce_r),
      .repeat_delay_ms    (delay_r),
      .repeat_interval_ms (interval_r),
      .rearm              (rearm_vec[i]),
      .flags              (flags[i])
    );

    assign pressed_vec[i] = flags[i].pressed;
    assign just_vec[i]    = flags[i].just;
    assign hit_vec[i]     = flags[i].hit;
  end

  logic             act_valid, act_repeat;
  logic [IDX_W-1:0] act_index;

  bda_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .req_action       (in_req_type),
    .allow_repeat     (in_allow_repeat),
    .just_vec         (just_vec),
    .hit_vec          (hit_vec),
    .rearm_vec        (rearm_vec),
    .action_valid     (act_valid),
    .action_index     (act_index),
    .action_is_repeat (act_repeat)
  );

  // Masks keep only the low bits that the output fields carry.
  result_t res;

  for (genvar j = 0; j < MASK_W; j++) begin : g_mask
    if (j < NUM_BUTTONS) begin : g_live
      assign res.pressed_mask[j]      = pressed_vec[j];
      assign res.just_pressed_mask[j] = just_vec[j];
    end else begin : g_pad
      assign res.pressed_mask[j]      = 1'b0;
      assign res.just_pressed_mask[j] = 1'b0;
    end
  end

  assign res.action_valid     = act_valid;
  assign res.action_index     = act_index;
  assign res.action_is_repeat = act_repeat;

  // Output register plus one skid entry.
  result_t out_r, skid_r;
  logic    out_valid_r, skid_valid_r;
  logic    out_take;

  assign out_take = out_valid_r && !out_stall;
  assign in_stall = skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_accept) begin
      if (out_valid_r && !out_take) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (in_accept) begin
      if (out_valid_r && !out_take) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_pressed_mask      = out_r.pressed_mask;
  assign out_just_pressed_mask = out_r.just_pressed_mask;
  assign out_action_valid      = out_r.action_valid;
  assign out_action_index      = out_r.action_index;
  assign out_action_is_repeat  = out_r.action_is_repeat;

endmodule

### rtl/bda_check.sv
// Port-level checker for the button debouncer with auto-repeat, and the
// bind that attaches it to the top level. Depends on bda_pkg.
module bda_check
  import bda_pkg::*;
#(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [MASK_W-1:0]  out_pressed_mask,
  input logic [MASK_W-1:0]  out_just_pressed_mask,
  input logic               out_action_valid,
  input logic [IDX_W-1:0]   out_action_index,
  input logic               out_action_is_repeat
);

  // A result with no action carries a zero index and no repeat flag.
  a_idle_action: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_action_valid) |-> (out_action_index == '0 && !out_action_is_repeat))
    else $error("idle action carries index or repeat flag");

  // Auto-repeat only fires in a frame with no new press anywhere.
  a_repeat_no_press: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action_is_repeat) |-> (out_action_valid && out_just_pressed_mask == '0))
    else $error("repeat action alongside a new press");

  // A newly pressed button is also in the debounced pressed set.
  a_just_subset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_just_pressed_mask & ~out_pressed_mask) == '0))
    else $error("just-pressed button not pressed");

  // A press action needs a visible new press when all buttons fit the mask.
  a_press_source: assert property (@(posedge clk) disable iff (!rst_n)
    (NUM_BUTTONS <= MASK_W && out_valid && out_action_valid && !out_action_is_repeat)
      |-> (out_just_pressed_mask != '0))
    else $error("press action without a new press");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_pressed_mask)
      && $stable(out_just_pressed_mask) && $stable(out_action_valid)
      && $stable(out_action_index) && $stable(out_action_is_repeat)))
    else $error("stalled result changed");

endmodule

bind button_debounce_autorepeat_top bda_check #(
  .NUM_BUTTONS (NUM_BUTTONS)
) u_bda_check (.*);

### sim/button_debounce_autorepeat_checker.sv
// Checker for the button debouncer: watches the request, result and config ports,
// predicts every result from its own copy of the button state and compares.
// Depends on bda_pkg for widths, register codes and the result layout.
module button_debounce_autorepeat_checker
  import bda_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_req_type,
  input  logic [RAW_W-1:0]  in_raw_levels,
  input  logic [TIME_W-1:0] in_now_ms,
  input  logic              in_allow_repeat,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [MASK_W-1:0] out_pressed_mask,
  input  logic [MASK_W-1:0] out_just_pressed_mask,
  input  logic              out_action_valid,
  input  logic [IDX_W-1:0]  out_action_index,
  input  logic              out_action_is_repeat,
  input  logic              cfg_we,
  input  cfg_reg_t          cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB = NUM_BUTTONS_DEF;

  logic [CFG_W-1:0]  debounce_ms;
  logic [CFG_W-1:0]  delay_ms;
  logic [CFG_W-1:0]  interval_ms;
  logic [NB-1:0]     btn_pressed;
  logic [NB-1:0]     btn_level;
  logic [TIME_W-1:0] change_ms [NB];
  logic [TIME_W-1:0] due_ms [NB];
  result_t           frame_q [$];

  // Advances the button state by one sample frame and queues the result it yields.
  task automatic predict_frame(input logic want_action, input logic [RAW_W-1:0] raw,
                               input logic [TIME_W-1:0] now, input logic allow);
    result_t           r;
    logic              level;
    logic [TIME_W-1:0] lag;
    logic [NB-1:0]     fresh;
    r = '0;
    fresh = '0;
    for (int b = 0; b < NB; b++) begin
      level = ~raw[b];
      if (level != btn_level[b]) change_ms[b] = now;
      lag = now - change_ms[b];
      if (lag > TIME_W'(debounce_ms) && level != btn_pressed[b]) begin
        btn_pressed[b] = level;
        if (level) begin
          fresh[b] = 1'b1;
          due_ms[b] = now + TIME_W'(delay_ms);
        end else begin
          due_ms[b] = '0;
        end
      end
      btn_level[b] = level;
    end
    if (want_action) begin
      for (int b = 0; b < NB; b++) begin
        if (!r.action_valid && fresh[b]) begin
          r.action_valid = 1'b1;
          r.action_index = IDX_W'(b);
        end
      end
      // A due time counts only when armed and not in the future, read as signed.
      for (int b = 0; b < NB; b++) begin
        lag = now - due_ms[b];
        if (allow && !r.action_valid && btn_pressed[b] && due_ms[b] != '0 &&
            !lag[TIME_W-1]) begin
          due_ms[b] = now + TIME_W'(interval_ms);
          r.action_valid = 1'b1;
          r.action_index = IDX_W'(b);
          r.action_is_repeat = 1'b1;
        end
      end
    end
    r.pressed_mask = btn_pressed;
    r.just_pressed_mask = fresh;
    frame_q.push_back(r);
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result();
    result_t frame;
    if (frame_q.size() == 0) begin
      $display("%0t: result with none pending, actual pressed 0x%0h just 0x%0h",
               $time, out_pressed_mask, out_just_pressed_mask);
      fail_count++;
    end else begin
      frame = frame_q.pop_front();
      check_field("pressed_mask", 32'(frame.pressed_mask), 32'(out_pressed_mask));
      check_field("just_pressed_mask", 32'(frame.just_pressed_mask),
                  32'(out_just_pressed_mask));
      check_field("action_valid", 32'(frame.action_valid), 32'(out_action_valid));
      check_field("action_index", 32'(frame.action_index), 32'(out_action_index));
      check_field("action_is_repeat", 32'(frame.action_is_repeat),
                  32'(out_action_is_repeat));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms = DEBOUNCE_RESET;
      delay_ms = DELAY_RESET;
      interval_ms = INTERVAL_RESET;
      btn_pressed = '0;
      btn_level = '0;
      for (int b = 0; b < NB; b++) begin
        change_ms[b] = '0;
        due_ms[b] = '0;
      end
      frame_q.delete();
    end else begin
      // Results leave after their request is taken, so retire before predicting.
      if (out_valid && !out_stall) check_result();
      if (cfg_we) begin
        case (cfg_index)
          REG_DEBOUNCE: debounce_ms = cfg_data;
          REG_DELAY:    delay_ms = cfg_data;
          REG_INTERVAL: interval_ms = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_frame(in_req_type, in_raw_levels, in_now_ms, in_allow_repeat);
      end
    end
    pending = frame_q.size();
  end

endmodule

### sim/button_debounce_autorepeat_top_tb.sv
// Testbench top for the button debouncer with auto-repeat: clock, reset, request
// stimulus, result back-pressure and the verdict. Needs bda_pkg, the RTL top
// and button_debounce_autorepeat_checker, which does all prediction and checking.
module button_debounce_autorepeat_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bda_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_req_type;
  logic [RAW_W-1:0]  in_raw_levels;
  logic [TIME_W-1:0] in_now_ms;
  logic              in_allow_repeat;
  logic              out_valid;
  logic              out_stall;
  logic [MASK_W-1:0] out_pressed_mask;
  logic [MASK_W-1:0] out_just_pressed_mask;
  logic              out_action_valid;
  logic [IDX_W-1:0]  out_action_index;
  logic              out_action_is_repeat;
  logic              cfg_we;
  cfg_reg_t          cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  int                fail_count;
  int                pending;

  // Requests accepted so far. Both sides look at it to place the stretch
  // without any idling and the long result hold-off.
  int   sent_cnt = 0;
  logic quiet;
  assign quiet = (sent_cnt >= 800) && (sent_cnt < 1000);

  button_debounce_autorepeat_top u_top (.*);

  button_debounce_autorepeat_checker u_checker (.*);

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Offers one sample frame and holds it until the block accepts it. Before
  // the offer the sender may idle outside the quiet stretch, so gaps land at
  // random points of the block's pipeline.
  task automatic send_frame(input logic req, input logic [RAW_W-1:0] raw,
                            input logic [TIME_W-1:0] now, input logic allow);
    while (!quiet && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_raw_levels   <= raw;
    in_now_ms       <= now;
    in_allow_repeat <= allow;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_cnt++;
  endtask

  // Stops offering requests and waits until every result has come back. Each
  // request yields exactly one result, so an empty checker queue means idle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Writes all three timing registers plus the unused index, which the
  // block must ignore. The enable is lowered only after the last write.
  task automatic write_regs(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] dly,
                            input logic [CFG_W-1:0] ivl, input logic [CFG_W-1:0] junk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DEBOUNCE;
    cfg_data  <= deb;
    @(posedge clk);
    cfg_index <= REG_DELAY;
    cfg_data  <= dly;
    @(posedge clk);
    cfg_index <= REG_INTERVAL;
    cfg_data  <= ivl;
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_data  <= junk;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random frames shaped like real button use: a target pattern is held for
  // a number of frames so that presses get through debounce and reach the
  // repeat times, with occasional contact bounce and large clock jumps that
  // exercise timestamp wrap and the signed due test. The step bound is
  // matched to the register setting of the phase.
  task automatic run_phase(input int frames, input int step_max);
    logic [RAW_W-1:0]  target;
    logic [RAW_W-1:0]  raw;
    logic [TIME_W-1:0] now;
    int                hold;
    int                n;
    now = $urandom;
    n = 0;
    while (n < frames) begin
      case ($urandom_range(0, 5))
        0:       target = '1;
        1:       target = '0;
        2:       target = ~(RAW_W'(1) << $urandom_range(0, RAW_W - 1));
        default: target = RAW_W'($urandom | $urandom);
      endcase
      hold = $urandom_range(1, 40);
      while (hold > 0 && n < frames) begin
        raw = target;
        if ($urandom_range(0, 99) < 8) raw = target ^ RAW_W'($urandom);
        if ($urandom_range(0, 99) < 2) now = now + $urandom;
        else now = now + $urandom_range(0, step_max);
        send_frame($urandom_range(0, 99) < 70, raw, now, $urandom_range(0, 99) < 80);
        hold--;
        n++;
      end
    end
  endtask

  // Result side: random back-pressure, none during the quiet stretch, and
  // one long hold-off while the sender keeps offering, so the output buffer
  // fills and the block has to stall its input.
  initial begin
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && sent_cnt >= 400) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
      end
      out_stall <= !quiet && ($urandom_range(0, 99) < 16);
    end
  end

  initial begin
    in_valid        <= 1'b0;
    in_req_type     <= 1'b0;
    in_raw_levels   <= '1;
    in_now_ms       <= '0;
    in_allow_repeat <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_DEBOUNCE;
    cfg_data        <= '0;
    rst_n           <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames at the reset timing of 50 / 350 / 120 ms. Levels are
    // active low, so 10'h3FF means nothing pressed.
    send_frame(1'b1, 10'h3FF, 32'd0, 1'b1);
    // All buttons go down; exactly the debounce time is not enough.
    send_frame(1'b1, 10'h000, 32'd10, 1'b1);
    send_frame(1'b1, 10'h000, 32'd60, 1'b1);
    // One more millisecond: every button presses, the lowest one wins.
    send_frame(1'b1, 10'h000, 32'd61, 1'b0);
    // Repeat not yet due, then due but repeat not allowed, then sample only.
    send_frame(1'b1, 10'h000, 32'd200, 1'b1);
    send_frame(1'b1, 10'h000, 32'd411, 1'b0);
    send_frame(1'b0, 10'h000, 32'd411, 1'b1);
    // Button 0 repeats and is re-armed, so button 1 takes the next one.
    send_frame(1'b1, 10'h000, 32'd411, 1'b1);
    send_frame(1'b1, 10'h000, 32'd411, 1'b1);
    // Near the top of the timestamp range, release everything but button 9.
    send_frame(1'b1, 10'h1FF, 32'hFFFF_FE00, 1'b1);
    send_frame(1'b1, 10'h1FF, 32'hFFFF_FE33, 1'b1);
    // Release and re-press button 9 so its press lands where the repeat
    // time sums to zero and the button stays disarmed while held.
    send_frame(1'b1, 10'h3FF, 32'hFFFF_FE34, 1'b1);
    send_frame(1'b1, 10'h3FF, 32'hFFFF_FE6E, 1'b1);
    send_frame(1'b1, 10'h1FF, 32'hFFFF_FE6F, 1'b1);
    send_frame(1'b1, 10'h1FF, 32'hFFFF_FEA2, 1'b1);
    send_frame(1'b1, 10'h1FF, 32'd0, 1'b1);
    send_frame(1'b1, 10'h1FF, 32'd500, 1'b1);
    // Button 0 joins; its repeat time of 1001 is checked half the range away.
    send_frame(1'b1, 10'h1FE, 32'd600, 1'b1);
    send_frame(1'b1, 10'h1FE, 32'd651, 1'b1);
    send_frame(1'b1, 10'h1FE, 32'd1001 + 32'h8000_0000, 1'b1);
    send_frame(1'b1, 10'h1FE, 32'd1001 + 32'h7FFF_FFFF, 1'b1);
    send_frame(1'b1, 10'h3FF, 32'hFFFF_FFFF, 1'b1);

    // Random phases, one per register setting, written only while idle.
    run_phase(326, 25);
    drain();
    write_regs('0, '0, '0, CFG_W'($urandom));
    run_phase(326, 3);
    drain();
    write_regs('1, '1, '1, CFG_W'($urandom));
    run_phase(326, 30000);
    drain();
    write_regs(CFG_W'($urandom_range(0, 30)), CFG_W'($urandom_range(0, 300)),
               CFG_W'($urandom_range(0, 150)), CFG_W'($urandom));
    run_phase(326, 25);
    drain();
    write_regs(DEBOUNCE_RESET, DELAY_RESET, INTERVAL_RESET, CFG_W'($urandom));
    run_phase(326, 25);

    // Let the last results come back, then a short settling margin.
    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
rtl/bda_pkg.sv
rtl/bda_lane.sv
rtl/bda_merge.sv
rtl/button_debounce_autorepeat_top.sv
rtl/bda_check.sv
sim/button_debounce_autorepeat_checker.sv
sim/button_debounce_autorepeat_top_tb.sv
